// ===== src/rpa_pkg.sv =====
// shared types, constants and elaboration-time cordic model for the polygon aperture test
// no dependencies
package rpa_pkg;

   localparam int CORDIC_ITERS = 24;
   localparam int GW = 35;                      // datapath width of g and cordic x/y
   localparam int MAX_BLADES_DEF = 16;
   localparam int COORD_BITS_DEF = 16;
   localparam int NB_RESET = 6;
   localparam int ROT_RESET = 2731;
   localparam longint KINV_Q30 = 64'sd652032874;
   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam int RECIP_SHIFT = 45;
   localparam int RW = 45;                      // reciprocal width

   localparam logic REG_NUM_BLADES = 1'b0;
   localparam logic REG_ROTATION = 1'b1;

   localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef struct packed {
      logic [15:0] u_coord;
      logic [15:0] v_coord;
   } req_word_type;

   typedef struct packed {
      logic        inside_res;
      logic [15:0] density;
   } rsp_word_type;

   // rotation cordic, used only to build constant tables
   function automatic longint cordic_rot(longint x0, longint y0, logic [31:0] a0,
                                         bit want_y);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      logic [31:0] a;
      x = x0;
      y = y0;
      a = a0;
      if (a >= 32'h40000000 && a < 32'hC0000000) begin
         x = -x;
         y = -y;
         a = a - 32'h80000000;
      end
      z = a[31] ? longint'(a) - 64'sd4294967296 : longint'(a);
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ATAN_TURNS[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ATAN_TURNS[i]);
         end
      end
      return want_y ? y : x;
   endfunction

   function automatic int clamp_blades(int v, int maxb);
      int n;
      n = v;
      if (n < 3) n = 3;
      if (n > maxb) n = maxb;
      return n;
   endfunction

endpackage

// ===== src/rpa_cordic_vec.sv =====
// pipelined vectoring cordic: angle of (x,y) as a 32-bit fraction of a turn
// depends on rpa_pkg
module rpa_cordic_vec (
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [rpa_pkg::GW-1:0] x_in,
   input  logic signed [rpa_pkg::GW-1:0] y_in,
   output logic [31:0]                  z_out
);
   import rpa_pkg::*;

   logic signed [GW-1:0] x_ff [CORDIC_ITERS+1];
   logic signed [GW-1:0] y_ff [CORDIC_ITERS+1];
   logic [31:0]          z_ff [CORDIC_ITERS+1];

   // fold left half plane onto the right
   always_ff @(posedge clock) begin
      if (enable) begin
         if (x_in[GW-1]) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            z_ff[0] <= 32'h80000000;
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      logic signed [GW-1:0] dx;
      logic signed [GW-1:0] dy;
      logic                 y_pos;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign y_pos = !y_ff[i][GW-1] && (y_ff[i] != '0);
      always_ff @(posedge clock) begin
         if (enable) begin
            if (y_pos) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + ATAN_TURNS[i];
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - ATAN_TURNS[i];
            end
         end
      end
   end

   assign z_out = z_ff[CORDIC_ITERS];
endmodule

// ===== src/rpa_cordic_rot.sv =====
// pipelined rotation cordic: x of (x,y) turned by a 32-bit angle, with cordic gain
// depends on rpa_pkg
module rpa_cordic_rot (
   input  logic                          clock,
   input  logic                          enable,
   input  logic signed [rpa_pkg::GW-1:0] x_in,
   input  logic signed [rpa_pkg::GW-1:0] y_in,
   input  logic [31:0]                   a_in,
   output logic signed [rpa_pkg::GW-1:0] x_out
);
   import rpa_pkg::*;

   localparam int ZW = 34;

   logic signed [GW-1:0] x_ff [CORDIC_ITERS+1];
   logic signed [GW-1:0] y_ff [CORDIC_ITERS+1];
   logic signed [ZW-1:0] z_ff [CORDIC_ITERS+1];
   logic                 flip;
   logic [31:0]          a_fold;

   assign flip = (a_in >= 32'h40000000) && (a_in < 32'hC0000000);
   assign a_fold = flip ? a_in - 32'h80000000 : a_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= flip ? -x_in : x_in;
         y_ff[0] <= flip ? -y_in : y_in;
         z_ff[0] <= ZW'(signed'(a_fold));
      end
   end

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      logic signed [GW-1:0] dx;
      logic signed [GW-1:0] dy;
      logic signed [ZW-1:0] at;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign at = ZW'(ATAN_TURNS[i]);
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + at;
            end
         end
      end
   end

   assign x_out = x_ff[CORDIC_ITERS];
endmodule

// ===== src/regular_polygon_aperture_test_core.sv =====
// top level of the polygon aperture test: csr port, sector logic, two cordic pipelines
// depends on rpa_pkg, rpa_cordic_vec, rpa_cordic_rot
// throughput: one word per cycle unless stalled; cordic stages are fully pipelined
// path from accept to result: input stage, 25-stage vectoring cordic, two sector
//   stages, 25-stage rotation cordic, output register
// a stall on the result side freezes the whole pipeline in place
// reset (synchronous) clears valid bits and loads num_blades 6, rotation 2731
module regular_polygon_aperture_test_core #(
   parameter int MAX_BLADES = rpa_pkg::MAX_BLADES_DEF,
   parameter int COORD_BITS = rpa_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rpa_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rpa_pkg::rsp_word_type rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import rpa_pkg::*;

   localparam int NW = $clog2(MAX_BLADES + 1);
   localparam int LAT = CORDIC_ITERS + 1;
   localparam int GDLY = LAT + 2;
   localparam int SDLY = LAT + 2 + LAT;
   localparam int PW = 32 + NW;
   localparam int MW = NW + 1;

   // csr
   logic [4:0]  nb_ff;
   logic [15:0] rot_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_ROTATION) ? {16'b0, rot_ff} : {27'b0, nb_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_ff  <= 5'(NB_RESET);
         rot_ff <= 16'(ROT_RESET);
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_NUM_BLADES: nb_ff  <= csr_pwdata[4:0];
            REG_ROTATION:   rot_ff <= csr_pwdata[15:0];
            default:        nb_ff  <= nb_ff;
         endcase
      end
   end

   // clamped side count
   logic [NW-1:0] neff;
   logic [7:0]    nb_ext;
   assign nb_ext = {3'b0, nb_ff};
   always_comb begin
      priority if (nb_ext < 8'd3) neff = NW'(3);
      else if (nb_ext > 8'(MAX_BLADES)) neff = NW'(MAX_BLADES);
      else neff = NW'(nb_ext);
   end

   // per-count constant roms, built at elaboration
   logic [RW-1:0]        recip_rom [MAX_BLADES+1];
   logic signed [GW-1:0] ex_rom    [MAX_BLADES+1];
   logic [15:0]          dens_rom  [MAX_BLADES+1];

   for (genvar gn = 0; gn <= MAX_BLADES; gn++) begin : g_rom
      localparam longint NV = longint'(clamp_blades(gn, MAX_BLADES));
      localparam longint SY = cordic_rot(KINV_Q30, 64'sd0,
                                         32'((64'sd1 <<< 32) / NV), 1'b1);
      localparam longint DD = (SY > 0) ? NV * SY : 64'sd1;
      localparam longint DQ = ((64'sd1 <<< 45) + DD / 2) / DD;
      localparam longint DS = (SY <= 0 || DQ > 65535) ? 64'sd65535 : DQ;
      localparam longint EX = cordic_rot(ONE_Q30, 64'sd0,
                                         32'((64'sd1 <<< 32) / (2 * NV)), 1'b0);
      localparam longint RC = ((64'sd1 <<< RECIP_SHIFT) + NV - 1) / NV;
      assign recip_rom[gn] = RW'(RC);
      assign ex_rom[gn]    = GW'(EX);
      assign dens_rom[gn]  = 16'(DS);
   end

   // pipeline control
   logic enable;
   logic rsp_valid_ff;
   assign enable = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = rsp_valid_ff;

   // input stage
   localparam logic [23:0] HALF = 24'(1) << (COORD_BITS - 1);
   logic [23:0]          u_ext;
   logic [23:0]          v_ext;
   logic [COORD_BITS-1:0] uc;
   logic [COORD_BITS-1:0] vc;
   logic signed [GW-1:0] gx_in;
   logic signed [GW-1:0] gy_in;
   logic                 v0_ff;
   logic                 org0_ff;
   logic signed [GW-1:0] gx0_ff;
   logic signed [GW-1:0] gy0_ff;

   assign u_ext = {8'b0, req_data.u_coord};
   assign v_ext = {8'b0, req_data.v_coord};
   assign uc = u_ext[COORD_BITS-1:0];
   assign vc = v_ext[COORD_BITS-1:0];
   assign gx_in = (GW'(uc) - GW'(HALF)) <<< (31 - COORD_BITS);
   assign gy_in = (GW'(vc) - GW'(HALF)) <<< (31 - COORD_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         org0_ff <= (uc == '0) && (vc == '0);
         gx0_ff  <= gx_in;
         gy0_ff  <= gy_in;
      end
   end

   // delay lines for g and the sideband
   logic signed [GW-1:0] gx_dly_ff [GDLY];
   logic signed [GW-1:0] gy_dly_ff [GDLY];
   logic [SDLY-1:0]      vld_dly_ff;
   logic [SDLY-1:0]      org_dly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_dly_ff <= '0;
      end else if (enable) begin
         vld_dly_ff <= {vld_dly_ff[SDLY-2:0], v0_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         org_dly_ff <= {org_dly_ff[SDLY-2:0], org0_ff};
         gx_dly_ff[0] <= gx0_ff;
         gy_dly_ff[0] <= gy0_ff;
         for (int i = 1; i < GDLY; i++) begin
            gx_dly_ff[i] <= gx_dly_ff[i-1];
            gy_dly_ff[i] <= gy_dly_ff[i-1];
         end
      end
   end

   // angle of g
   logic [31:0] z_ang;
   rpa_cordic_vec u_vec (
      .clock  (clock),
      .enable (enable),
      .x_in   (gx0_ff),
      .y_in   (gy0_ff),
      .z_out  (z_ang)
   );

   // sector index, then sector centre offset via reciprocal multiply
   logic [31:0]       rot_ang;
   logic [31:0]       phi;
   logic [PW-1:0]     k_prod;
   logic [NW-1:0]     k_ff;
   logic [MW-1:0]     m_odd;
   logic [MW+RW-1:0]  off_prod;
   logic [31:0]       off_ff;
   logic [31:0]       psi;

   assign rot_ang = {rot_ff, 16'b0};
   assign phi = z_ang - rot_ang;
   assign k_prod = PW'(phi) * PW'(neff);
   assign m_odd = {k_ff, 1'b1};
   assign off_prod = (MW+RW)'(m_odd) * (MW+RW)'(recip_rom[neff]);
   assign psi = rot_ang + off_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         k_ff   <= k_prod[32 +: NW];
         off_ff <= off_prod[RECIP_SHIFT-31 +: 32];
      end
   end

   // turn g back by the sector centre angle
   logic signed [GW-1:0] x_rot;
   rpa_cordic_rot u_rot (
      .clock  (clock),
      .enable (enable),
      .x_in   (gx_dly_ff[GDLY-1]),
      .y_in   (gy_dly_ff[GDLY-1]),
      .a_in   (32'd0 - psi),
      .x_out  (x_rot)
   );

   // output register
   logic in_poly;
   assign in_poly = org_dly_ff[SDLY-1] || (x_rot <= ex_rom[neff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= vld_dly_ff[SDLY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_data.inside_res <= in_poly;
         rsp_data.density    <= in_poly ? dens_rom[neff] : 16'd0;
      end
   end

   // checks
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.inside_res |-> rsp_data.density == 16'd0)
      else $error("outside result with nonzero density");

   a_origin_inside: assert property (@(posedge clock) disable iff (reset)
      enable && vld_dly_ff[SDLY-1] && org_dly_ff[SDLY-1] |=> rsp_data.inside_res)
      else $error("origin corner not reported inside");

   a_neff_range: assert property (@(posedge clock) disable iff (reset)
      neff >= NW'(3) && neff <= NW'(MAX_BLADES))
      else $error("side count out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(vld_dly_ff) && $stable(v0_ff))
      else $error("pipeline moved during stall");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      k_ff < neff || !vld_dly_ff[LAT])
      else $error("sector index out of range");
endmodule
